// ----- sv/assert_macros.svh -----
// Assertion helpers shared by the RTL. Each assertion is clocked by clk_i
// and disabled while rst_ni is low, so the using module must have both.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

`define ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define ASSERT_IMPL(label, ante, cons)

`define ASSERT_NEXT(label, ante, cons)

`endif

`endif

// ----- sv/mad_pkg.sv -----
`default_nettype none

package mad_pkg;

  localparam int MaxWindow   = 64;
  localparam int IdxW        = $clog2(MaxWindow);
  localparam int WinW        = IdxW + 1;
  localparam int SampleW     = 32;
  localparam int SumW        = SampleW + IdxW;
  localparam int DiffW       = SampleW + 1;
  localparam int DivSteps    = SumW;
  localparam int DivCntW     = $clog2(DivSteps);

  localparam logic [WinW-1:0] WindowReset = WinW'(MaxWindow);

  typedef logic signed [SampleW-1:0] sample_t;
  typedef logic signed [SumW-1:0]    sum_t;
  typedef logic signed [DiffW-1:0]   diff_t;
  typedef logic        [WinW-1:0]    win_t;
  typedef logic        [IdxW-1:0]    idx_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

`default_nettype wire

// ----- sv/mad_ifs.sv -----
`default_nettype none

interface mad_cfg_if;
  import mad_pkg::*;
  logic valid;
  logic ready;
  win_t window_len;
  modport source (output valid, output window_len, input ready);
  modport sink   (input valid, input window_len, output ready);
endinterface

interface mad_sample_if;
  import mad_pkg::*;
  logic    valid;
  logic    ready;
  sample_t sample;
  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface mad_result_if;
  import mad_pkg::*;
  logic    valid;
  logic    ready;
  sample_t average;
  diff_t   difference;
  modport source (output valid, output average, output difference, input ready);
  modport sink   (input valid, input average, input difference, output ready);
endinterface

`default_nettype wire

// ----- sv/mad_ring_ram.sv -----
`default_nettype none

module mad_ring_ram (
  input  logic                clk_i,
  input  logic                we_i,
  input  logic [mad_pkg::IdxW-1:0] waddr_i,
  input  mad_pkg::sample_t    wdata_i,
  input  logic                re_i,
  input  logic [mad_pkg::IdxW-1:0] raddr_i,
  output mad_pkg::sample_t    rdata_o
);
  import mad_pkg::*;

  sample_t mem [MaxWindow];
  sample_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ----- sv/mad_divider.sv -----
`default_nettype none

module mad_divider (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  mad_pkg::sum_t      dividend_i,
  input  mad_pkg::win_t      divisor_i,
  output mad_pkg::sum_t      quotient_o,
  output mad_pkg::div_stat_t stat_o
);
  import mad_pkg::*;

  logic [SumW-1:0]    quo_q, quo_d;
  logic [WinW-1:0]    rem_q, rem_d;
  win_t               div_q, div_d;
  logic [DivCntW-1:0] cnt_q, cnt_d;
  logic               neg_q, neg_d;
  logic               busy_q, busy_d;
  logic               done_q, done_d;

  logic [WinW:0]   trial;
  logic [WinW:0]   trial_sub;
  logic            ge;
  logic [SumW-1:0] mag;

  // Restoring division on magnitudes, one quotient bit per cycle; the sign
  // is applied at the end so the result truncates toward zero.
  always_comb begin
    trial     = {rem_q, quo_q[SumW-1]};
    ge        = trial >= {1'b0, div_q};
    trial_sub = trial - {1'b0, div_q};
    mag       = dividend_i[SumW-1] ? (-dividend_i) : dividend_i;

    quo_d  = quo_q;
    rem_d  = rem_q;
    div_d  = div_q;
    cnt_d  = cnt_q;
    neg_d  = neg_q;
    busy_d = busy_q;
    done_d = 1'b0;

    if (start_i) begin
      quo_d  = mag;
      rem_d  = '0;
      div_d  = divisor_i;
      cnt_d  = DivCntW'(DivSteps - 1);
      neg_d  = dividend_i[SumW-1];
      busy_d = 1'b1;
    end else if (busy_q) begin
      quo_d = {quo_q[SumW-2:0], ge};
      rem_d = ge ? trial_sub[WinW-1:0] : trial[WinW-1:0];
      cnt_d = cnt_q - DivCntW'(1);
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    div_q <= div_d;
    neg_q <= neg_d;
  end

  assign quotient_o  = neg_q ? sum_t'(-quo_q) : sum_t'(quo_q);
  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;

endmodule

`default_nettype wire

// ----- sv/moving_average_difference.sv -----
`default_nettype none
`include "assert_macros.svh"

// Moving average over a ring of the last 64 signed Q16.16 samples, giving
// the mean and the sample minus the mean for every sample taken. Until the
// ring has wrapped once the mean covers only the samples seen so far; after
// that it covers window_len samples (0 acts as 1, above 64 acts as 64), and
// the mean is truncated toward zero and saturated to 32 bits. The oldest
// ring entry is read at the transfer itself. The update state updates the
// running sum, writes the memory back and starts the divider, which
// produces one quotient bit a cycle. The divide state sees the divider
// finish, and the output state loads the output register, waiting while
// the last result is untaken. The next sample can be taken only after that
// load. A new sample is taken once the previous one has reached the output
// register, even if that result is still waiting to be taken. Change
// window_len only while idle, and reset the block after changing it
// mid-stream for a clean window.
module moving_average_difference (
  input  logic         clk_i,
  input  logic         rst_ni,
  mad_cfg_if.sink      cfg_i,
  mad_sample_if.sink   sample_i,
  mad_result_if.source result_o
);
  import mad_pkg::*;

  localparam logic [1:0] StIdle   = 2'd0;
  localparam logic [1:0] StUpdate = 2'd1;
  localparam logic [1:0] StDiv    = 2'd2;
  localparam logic [1:0] StOut    = 2'd3;

  logic [1:0]           state_q, state_d;
  win_t                 window_q;
  sample_t              sample_q;
  sum_t                 sum_q, sum_d;
  idx_t                 idx_q, idx_d;
  logic                 filled_q, filled_d;
  logic [MaxWindow-1:0] valid_q;
  logic                 out_valid_q;
  sample_t              avg_q;
  diff_t                diff_q;

  logic      in_fire;
  logic      out_free;
  win_t      eff_win;
  win_t      idx_next;
  sample_t   ram_rdata;
  sample_t   old_sample;
  logic      div_start;
  win_t      divisor;
  sum_t      quotient;
  div_stat_t div_stat;
  sample_t   avg_sat;
  diff_t     diff_val;

  assign cfg_i.ready    = 1'b1;
  assign sample_i.ready = (state_q == StIdle);
  assign in_fire        = sample_i.valid && sample_i.ready;
  assign out_free       = !out_valid_q || result_o.ready;

  always_comb begin
    if (window_q >= WinW'(MaxWindow)) begin
      eff_win = WinW'(MaxWindow);
    end else if (window_q == '0) begin
      eff_win = WinW'(1);
    end else begin
      eff_win = window_q;
    end
  end

  assign idx_next   = WinW'(idx_q) + WinW'(1);
  assign old_sample = valid_q[idx_q] ? ram_rdata : '0;
  assign div_start  = (state_q == StUpdate);
  assign divisor    = filled_q ? eff_win : idx_next;

  mad_ring_ram u_ram (
    .clk_i   (clk_i),
    .we_i    (div_start),
    .waddr_i (idx_q),
    .wdata_i (sample_q),
    .re_i    (in_fire),
    .raddr_i (idx_q),
    .rdata_o (ram_rdata)
  );

  mad_divider u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (sum_d),
    .divisor_i  (divisor),
    .quotient_o (quotient),
    .stat_o     (div_stat)
  );

  always_comb begin
    state_d  = state_q;
    sum_d    = sum_q;
    idx_d    = idx_q;
    filled_d = filled_q;
    case (state_q)
      StIdle: begin
        if (in_fire) begin
          state_d = StUpdate;
        end
      end
      StUpdate: begin
        sum_d = sum_q - sum_t'(old_sample) + sum_t'(sample_q);
        if (idx_next >= eff_win) begin
          idx_d    = '0;
          filled_d = 1'b1;
        end else begin
          idx_d = idx_next[IdxW-1:0];
        end
        state_d = StDiv;
      end
      StDiv: begin
        if (div_stat.done) begin
          state_d = StOut;
        end
      end
      StOut: begin
        if (out_free) begin
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // The quotient fits in SumW bits; clamp it to the 32-bit sample range.
  always_comb begin
    if (quotient[SumW-1:SampleW-1] == '0 || quotient[SumW-1:SampleW-1] == '1) begin
      avg_sat = quotient[SampleW-1:0];
    end else if (quotient[SumW-1]) begin
      avg_sat = {1'b1, {(SampleW-1){1'b0}}};
    end else begin
      avg_sat = {1'b0, {(SampleW-1){1'b1}}};
    end
    diff_val = diff_t'(sample_q) - diff_t'(avg_sat);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      window_q    <= WindowReset;
      sum_q       <= '0;
      idx_q       <= '0;
      filled_q    <= 1'b0;
      valid_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      sum_q    <= sum_d;
      idx_q    <= idx_d;
      filled_q <= filled_d;
      if (cfg_i.valid && cfg_i.ready) begin
        window_q <= cfg_i.window_len;
      end
      if (div_start) begin
        valid_q[idx_q] <= 1'b1;
      end
      if (state_q == StOut && out_free) begin
        out_valid_q <= 1'b1;
      end else if (result_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      sample_q <= sample_i.sample;
    end
    if (state_q == StOut && out_free) begin
      avg_q  <= avg_sat;
      diff_q <= diff_val;
    end
  end

  assign result_o.valid      = out_valid_q;
  assign result_o.average    = avg_q;
  assign result_o.difference = diff_q;

  `ASSERT_NEXT(a_accept_to_update, in_fire, state_q == StUpdate)
  `ASSERT_IMPL(a_div_idle_on_start, div_start, !div_stat.busy)
  `ASSERT_IMPL(a_result_from_out, $rose(out_valid_q), $past(state_q) == StOut)
  `ASSERT_NEXT(a_filled_sticks, filled_q, filled_q)
  `ASSERT_IMPL(a_done_in_div, div_stat.done, state_q == StDiv)

endmodule

`default_nettype wire
